FILE: rtl/core/lcu_pkg.sv
`default_nettype none

package lcu_pkg;

   localparam int Q           = 3329;
   localparam int DATA_W      = 12;
   localparam int FUNC_W      = 3;
   localparam int P_BITS_W    = 4;
   localparam logic [P_BITS_W-1:0] P_BITS_RESET = P_BITS_W'(10);

   localparam int SHIFT_MAX   = 2**P_BITS_W - 1;
   localparam int SUM_W       = DATA_W + 1;
   localparam int SCALED_W    = SUM_W + SHIFT_MAX;
   localparam int Q_BITS      = $clog2(Q);
   localparam int RECIP_SHIFT = SCALED_W + Q_BITS;
   localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) + 64'(Q) - 64'd1) / 64'(Q);
   localparam int RECIP_W     = $clog2(RECIP + 64'd1);
   localparam int PROD_W      = SCALED_W + RECIP_W;
   localparam int DEQ_W       = DATA_W + Q_BITS + 1;

   localparam int HALF_Q      = Q / 2;
   localparam int DECODE_LO   = Q / 4;
   localparam int DECODE_HI   = (3 * Q) / 4;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SUB    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUANT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_DEQUANT = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_ENCODE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_DECODE = 3'd5;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
   } op_type;

endpackage

`default_nettype wire

FILE: rtl/core/lcu_csr.sv
`default_nettype none

module lcu_csr
   import lcu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire logic [P_BITS_W-1:0] wr_data,
   output logic      [P_BITS_W-1:0] p_bits
);

   logic [P_BITS_W-1:0] p_bits_ff;
   logic [P_BITS_W-1:0] p_bits_in;

   always_comb begin
      p_bits_in = wr_en ? wr_data : p_bits_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_bits_ff <= P_BITS_RESET;
      end else begin
         p_bits_ff <= p_bits_in;
      end
   end

   assign p_bits = p_bits_ff;

endmodule

`default_nettype wire

FILE: rtl/core/lcu_alu.sv
`default_nettype none

module lcu_alu
   import lcu_pkg::*;
(
   input  wire op_type              op,
   input  wire logic [P_BITS_W-1:0] p_bits,
   output logic      [DATA_W-1:0]   result
);

   logic [SUM_W-1:0]    sum;
   logic [SUM_W-1:0]    add_res;
   logic [DATA_W-1:0]   diff;
   logic [DATA_W-1:0]   sub_res;
   logic [SCALED_W-1:0] scaled;
   logic [PROD_W-1:0]   prod;
   logic [DATA_W-1:0]   quot;
   logic [SHIFT_MAX:0]  p_mask;
   logic [DATA_W-1:0]   quant_res;
   logic [DEQ_W-1:0]    deq_sum;
   logic [DEQ_W-1:0]    deq_shift;
   logic [DATA_W-1:0]   enc_res;
   logic                dec_bit;

   always_comb begin
      sum     = {1'b0, op.operand_a} + {1'b0, op.operand_b};
      add_res = (int'(sum) >= Q) ? sum - SUM_W'(Q) : sum;

      diff    = op.operand_a - op.operand_b;
      sub_res = (op.operand_b > op.operand_a) ? diff + DATA_W'(Q) : diff;

      // floor(x * 2^p / Q) by exact reciprocal multiply
      scaled    = SCALED_W'(sum) << p_bits;
      prod      = PROD_W'(scaled) * PROD_W'(RECIP_W'(RECIP));
      quot      = prod[RECIP_SHIFT +: DATA_W];
      p_mask    = ((SHIFT_MAX+1)'(1) << p_bits) - (SHIFT_MAX+1)'(1);
      quant_res = quot & p_mask[DATA_W-1:0];

      deq_sum   = DEQ_W'(op.operand_a) * DEQ_W'(Q) + DEQ_W'(HALF_Q);
      deq_shift = deq_sum >> p_bits;

      enc_res = op.operand_a[0] ? DATA_W'(HALF_Q) : '0;
      dec_bit = (int'(op.operand_a) > DECODE_LO) && (int'(op.operand_a) < DECODE_HI);

      unique case (op.func)
         FUNC_ADD:     result = add_res[DATA_W-1:0];
         FUNC_SUB:     result = sub_res;
         FUNC_QUANT:   result = quant_res;
         FUNC_DEQUANT: result = deq_shift[DATA_W-1:0];
         FUNC_ENCODE:  result = enc_res;
         FUNC_DECODE:  result = {{(DATA_W-1){1'b0}}, dec_bit};
         default:      result = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/lattice_coefficient_unit.sv
`default_nettype none

// Lattice coefficient unit: add, sub, quantize, dequantize, encode and
// decode on one polynomial coefficient per transaction.
// Request channel: req_valid with req_func, req_operand_a, req_operand_b;
// a transaction is taken on a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid with rsp_result, taken when rsp_stall is low.
// Config: csr_wr_en writes csr_wr_data into p_bits (log2 P); write only
// while no transaction is in flight.
// Path: a transaction is held in the operand register, and its result is
// then registered in the result register, from which it is taken.
// Throughput: one transaction per cycle while the receiver does not stall,
// set by the single pass through the reciprocal multiplier for quantize.
// Reset (synchronous, active high) empties both stages and sets p_bits to 10.
// When the receiver stalls, the result register holds; the operand stage
// takes one more transaction only if it is empty, then req_stall rises until
// the result is taken.

module lattice_coefficient_unit
   import lcu_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [DATA_W-1:0]   req_operand_a,
   input  wire logic [DATA_W-1:0]   req_operand_b,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DATA_W-1:0]   rsp_result,
   input  wire logic                csr_wr_en,
   input  wire logic [P_BITS_W-1:0] csr_wr_data
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   op_type              s1_op_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [DATA_W-1:0]   rsp_result_ff;
   logic [DATA_W-1:0]   alu_result;
   logic [P_BITS_W-1:0] p_bits;
   logic                out_load;
   logic                s1_load;

   lcu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .wr_data (csr_wr_data),
      .p_bits  (p_bits)
   );

   lcu_alu u_alu (
      .op     (s1_op_ff),
      .p_bits (p_bits),
      .result (alu_result)
   );

   always_comb begin
      out_load     = !rsp_valid_ff || !rsp_stall;
      req_stall    = s1_valid_ff && !out_load;
      s1_load      = req_valid && !req_stall;
      s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_op_ff.func      <= req_func;
         s1_op_ff.operand_a <= req_operand_a;
         s1_op_ff.operand_b <= req_operand_b;
      end
      if (out_load && s1_valid_ff) begin
         rsp_result_ff <= alu_result;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

`default_nettype wire
